// File: hdl/peak_valley_sag_tracker_defines.svh
// Assertion macros shared by the tracker modules.
// Every macro takes a label, the clock, the active-low reset and the checked expressions.
`ifndef PEAK_VALLEY_SAG_TRACKER_DEFINES_SVH
`define PEAK_VALLEY_SAG_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF

`define PVST_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`define PVST_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define PVST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define PVST_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define PVST_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define PVST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/pvst_pkg.sv
package pvst_pkg;

	// Threshold registers are 15 bits wide whatever the sample width.
	localparam int THR_BITS = 15;
	localparam logic [THR_BITS-1:0] THR_RESET = 15'd2867;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_THR = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SAG_THR  = 2'd1;

	typedef enum logic [1:0] {
		KIND_PEAK       = 2'd0,
		KIND_SMALL_PEAK = 2'd1,
		KIND_VALLEY     = 2'd2,
		KIND_SAG        = 2'd3
	} event_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // request accepted: classify and accumulate
		logic div_init;  // load the divider from the selected sum and count
		logic div_step;  // one quotient bit
		logic out_load;  // move the finished event into the output register
	} pvst_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic event_hit; // the incoming request completes a peak or a valley
		logic needs_div; // the pending event reports an average
	} pvst_sts_t;

endpackage

// File: hdl/pvst_dp.sv
module pvst_dp import pvst_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pvst_cmd_t                     cmd,
	output pvst_sts_t                     sts,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [THR_BITS-1:0]           cfg_data,
	output logic [1:0]                    event_kind,
	output logic signed [SAMPLE_BITS-1:0] extreme_value,
	output logic signed [SAMPLE_BITS-1:0] running_average
);

	localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
	localparam int CMP_BITS = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;

	logic [THR_BITS-1:0]           peak_thr_q, sag_thr_q;
	logic signed [SAMPLE_BITS-1:0] newest_q, older_q;
	logic signed [SUM_BITS-1:0]    peak_sum_q, valley_sum_q;
	logic [COUNT_BITS-1:0]         peak_cnt_q, valley_cnt_q;
	event_kind_t                   kind_q;
	logic signed [SAMPLE_BITS-1:0] extreme_q;
	logic [COUNT_BITS-1:0]         rem_q, divisor_q;
	logic [SAMPLE_BITS-1:0]        quot_q;
	logic                          neg_q;
	event_kind_t                   out_kind_q;
	logic signed [SAMPLE_BITS-1:0] out_ext_q, out_avg_q;

	logic                          is_peak, is_valley, peak_big, valley_deep;
	logic signed [CMP_BITS-1:0]    mid_ext, peak_thr_ext, sag_neg;
	logic signed [SUM_BITS-1:0]    sel_sum;
	logic [SUM_BITS-1:0]           sum_abs;
	logic [COUNT_BITS:0]           trial, diff;
	logic                          ge;
	event_kind_t                   kind_d;

	// Classification of the middle sample against its two neighbors.
	always_comb begin
		is_peak      = (newest_q > older_q) && (newest_q > sample);
		is_valley    = (newest_q < older_q) && (newest_q < sample);
		mid_ext      = CMP_BITS'(newest_q);
		peak_thr_ext = signed'({{(CMP_BITS-THR_BITS){1'b0}}, peak_thr_q});
		sag_neg      = -signed'({{(CMP_BITS-THR_BITS){1'b0}}, sag_thr_q});
		peak_big     = mid_ext >= peak_thr_ext;
		valley_deep  = mid_ext <= sag_neg;
		if (is_peak) begin
			kind_d = peak_big ? KIND_PEAK : KIND_SMALL_PEAK;
		end else begin
			kind_d = valley_deep ? KIND_VALLEY : KIND_SAG;
		end
	end

	assign sts.event_hit = is_peak || is_valley;
	assign sts.needs_div = (kind_q == KIND_PEAK) || (kind_q == KIND_VALLEY);

	// Divider operands: magnitude of the sum, the count as divisor.
	always_comb begin
		sel_sum = (kind_q == KIND_VALLEY) ? valley_sum_q : peak_sum_q;
		sum_abs = sel_sum[SUM_BITS-1] ? SUM_BITS'(-sel_sum) : SUM_BITS'(sel_sum);
		trial   = {rem_q, quot_q[SAMPLE_BITS-1]};
		diff    = trial - {1'b0, divisor_q};
		ge      = trial >= {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_thr_q   <= THR_RESET;
			sag_thr_q    <= THR_RESET;
			newest_q     <= '0;
			older_q      <= '0;
			peak_sum_q   <= '0;
			valley_sum_q <= '0;
			peak_cnt_q   <= '0;
			valley_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PEAK_THR: peak_thr_q <= cfg_data;
					CFG_SAG_THR:  sag_thr_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				older_q  <= newest_q;
				newest_q <= sample;
				if (is_peak && peak_big && (peak_cnt_q != '1)) begin
					peak_sum_q <= peak_sum_q + SUM_BITS'(newest_q);
					peak_cnt_q <= peak_cnt_q + 1'b1;
				end
				if (is_valley && valley_deep && (valley_cnt_q != '1)) begin
					valley_sum_q <= valley_sum_q + SUM_BITS'(newest_q);
					valley_cnt_q <= valley_cnt_q + 1'b1;
				end
			end
		end
	end

	// The quotient fits in SAMPLE_BITS bits, so the upper part of the
	// dividend is already below the divisor and seeds the remainder.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind_d;
			extreme_q <= newest_q;
		end
		if (cmd.div_init) begin
			rem_q     <= sum_abs[SUM_BITS-1:SAMPLE_BITS];
			quot_q    <= sum_abs[SAMPLE_BITS-1:0];
			neg_q     <= sel_sum[SUM_BITS-1];
			divisor_q <= (kind_q == KIND_VALLEY) ? valley_cnt_q : peak_cnt_q;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quot_q <= {quot_q[SAMPLE_BITS-2:0], ge};
		end
		if (cmd.out_load) begin
			out_kind_q <= kind_q;
			out_ext_q  <= extreme_q;
			if (sts.needs_div) begin
				out_avg_q <= neg_q ? signed'(SAMPLE_BITS'(-quot_q)) : signed'(quot_q);
			end else begin
				out_avg_q <= '0;
			end
		end
	end

	assign event_kind      = out_kind_q;
	assign extreme_value   = out_ext_q;
	assign running_average = out_avg_q;

endmodule

// File: hdl/pvst_ctrl.sv
`include "peak_valley_sag_tracker_defines.svh"

module pvst_ctrl import pvst_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  pvst_sts_t sts,
	output pvst_cmd_t cmd
);

	localparam int CNT_BITS = $clog2(SAMPLE_BITS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_DIV  = 4'b0100,
		S_LOAD = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                accept, slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.load     = accept;
		unique case (state_q)
			S_IDLE: begin
				if (accept && sts.event_hit) state_d = S_PREP;
			end
			S_PREP: begin
				cmd.div_init = 1'b1;
				state_d = sts.needs_div ? S_DIV : S_LOAD;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) state_d = S_LOAD;
			end
			S_LOAD: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PREP) begin
				cnt_q <= CNT_BITS'(SAMPLE_BITS - 1);
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`PVST_ASSERT_NEXT(a_no_event_ready, clk, arst_n, accept && !sts.event_hit, state_q == S_IDLE)
	`PVST_ASSERT_NEXT(a_div_ends, clk, arst_n, state_q == S_DIV && cnt_q == '0, state_q == S_LOAD)
	`PVST_ASSERT_IMPLIES(a_load_free, clk, arst_n, cmd.out_load, !out_valid_q || !out_stall)
	`PVST_ASSERT_NEXT(a_held_result, clk, arst_n, out_valid_q && out_stall, out_valid_q)

endmodule

// File: hdl/peak_valley_sag_tracker.sv
// Peak, valley and sag tracker for signed fixed-point voltage samples. Each
// request carries one sample; the block keeps the two previous samples (both
// zero after reset) and judges the middle one: strictly above both neighbors
// is a peak, strictly below both is a valley, anything with an equal neighbor
// gives no result. A peak at or above peak_threshold is added to the peak sum
// and count and reported with the peak average (event_kind 0); a smaller peak
// is reported as event_kind 1. A valley at or below minus sag_threshold goes
// into the valley average (event_kind 2); a shallower valley is a sag
// (event_kind 3). Averages are sum divided by count, truncated toward zero,
// and running_average is zero for kinds 1 and 3. A count that has reached its
// maximum stops the accumulation but the event is still reported. A request
// with no result leaves the block idle; a small peak or sag passes through
// divider setup to the output load, and an event with an average also runs
// the shared restoring divider, which produces one quotient bit per cycle.
// Results leave through an output register, so the next request is taken
// while an earlier result still waits on out_stall. The configuration
// port is always ready; register 0 is peak_threshold, register 1 is
// sag_threshold, other indexes are ignored, and it should be written only
// while the block is idle.
module peak_valley_sag_tracker import pvst_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample request channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// Event result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    event_kind,
	output logic signed [SAMPLE_BITS-1:0] extreme_value,
	output logic signed [SAMPLE_BITS-1:0] running_average,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [THR_BITS-1:0]           cfg_data
);

	pvst_cmd_t cmd;
	pvst_sts_t sts;

	// Threshold writes are taken in any cycle.
	assign cfg_ready = 1'b1;

	// The controller sequences accept, divider setup, the division steps and
	// the hand-off to the output register.
	pvst_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the sample history, the accumulators, the
	// thresholds, the divider and the output register.
	pvst_dp #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sample          (sample),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.event_kind      (event_kind),
		.extreme_value   (extreme_value),
		.running_average (running_average)
	);

endmodule

// File: sim/pvst_checker.sv
`timescale 1ns / 100ps

// Watches the sample, event and register channels of the tracker. It keeps
// its own copy of the two prior samples and of the peak and valley sums and
// counts, and predicts the event, if any, for every accepted request.
module pvst_checker import pvst_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [1:0]                    event_kind,
	input  logic signed [SAMPLE_BITS-1:0] extreme_value,
	input  logic signed [SAMPLE_BITS-1:0] running_average,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [THR_BITS-1:0]           cfg_data,
	output int                            fail_count,
	output int                            pending
);

	typedef struct {
		event_kind_t                   kind;
		logic signed [SAMPLE_BITS-1:0] extreme;
		logic signed [SAMPLE_BITS-1:0] average;
	} tracker_event_t;

	localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

	logic [THR_BITS-1:0]           peak_thr;
	logic [THR_BITS-1:0]           sag_thr;
	logic signed [SAMPLE_BITS-1:0] newer_sample;
	logic signed [SAMPLE_BITS-1:0] older_sample;
	longint                        peak_total;
	longint                        peak_hits;
	longint                        valley_total;
	longint                        valley_hits;
	tracker_event_t                expected_events[$];
	tracker_event_t                oldest;

	// Quotient truncated toward zero; an empty average reads zero.
	function automatic longint mean_of(input longint total, input longint hits);
		if (hits == 0)
			return 0;
		return total / hits;
	endfunction

	function automatic void compare_field(input string name,
			input logic signed [SAMPLE_BITS-1:0] want,
			input logic signed [SAMPLE_BITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic track_sample(input logic signed [SAMPLE_BITS-1:0] right);
		logic signed [SAMPLE_BITS-1:0] mid;
		logic signed [SAMPLE_BITS-1:0] left;
		tracker_event_t                ev;
		mid = newer_sample;
		left = older_sample;
		older_sample = newer_sample;
		newer_sample = right;
		ev.extreme = mid;
		ev.average = '0;
		if (mid > left && mid > right) begin
			if (int'(mid) >= int'(peak_thr)) begin
				if (peak_hits < COUNT_MAX) begin
					peak_total += int'(mid);
					peak_hits++;
				end
				ev.kind = KIND_PEAK;
				ev.average = SAMPLE_BITS'(mean_of(peak_total, peak_hits));
			end else begin
				ev.kind = KIND_SMALL_PEAK;
			end
			expected_events.push_back(ev);
		end else if (mid < left && mid < right) begin
			if (int'(mid) <= -int'(sag_thr)) begin
				if (valley_hits < COUNT_MAX) begin
					valley_total += int'(mid);
					valley_hits++;
				end
				ev.kind = KIND_VALLEY;
				ev.average = SAMPLE_BITS'(mean_of(valley_total, valley_hits));
			end else begin
				ev.kind = KIND_SAG;
			end
			expected_events.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_thr = THR_RESET;
			sag_thr = THR_RESET;
			newer_sample = '0;
			older_sample = '0;
			peak_total = 0;
			peak_hits = 0;
			valley_total = 0;
			valley_hits = 0;
			expected_events.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					$error("event with none expected: kind %0d, value %0d, average %0d",
						event_kind, extreme_value, running_average);
					fail_count++;
				end else begin
					oldest = expected_events.pop_front();
					compare_field("event_kind", oldest.kind, event_kind);
					compare_field("extreme_value", oldest.extreme, extreme_value);
					compare_field("running_average", oldest.average, running_average);
				end
			end
			if (in_valid && !in_stall)
				track_sample(sample);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PEAK_THR: peak_thr = cfg_data;
					CFG_SAG_THR:  sag_thr = cfg_data;
					default: ;
				endcase
			end
		end
		pending = expected_events.size();
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

// Top of the tracker bench. It only makes stimulus and gives the verdict;
// the checker beside the block predicts every event and compares it.
module tb_top;
	import pvst_pkg::*;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	// A request with an average keeps the block busy through the divider, so
	// SETTLE_CYCLES quiet cycles are enough for the block to settle.
	localparam int SETTLE_CYCLES     = SAMPLE_BITS + 8;
	localparam int RANDOM_BLOCKS     = 6;
	localparam int ITEMS_PER_BLOCK   = 270;
	localparam int LONG_HOLD_CYCLES  = 400;
	// Indexes that name no register; writes to them must change nothing.
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

	// Who idles: first the receiver mostly, then the sender, then nobody.
	typedef enum logic [1:0] {
		ERA_SLOW_SINK,
		ERA_SLOW_SOURCE,
		ERA_FULL_RATE
	} era_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    event_kind;
	logic signed [SAMPLE_BITS-1:0] extreme_value;
	logic signed [SAMPLE_BITS-1:0] running_average;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_BITS-1:0]       cfg_index = CFG_PEAK_THR;
	logic [THR_BITS-1:0]           cfg_data = '0;
	int                            fail_count;
	int                            pending;

	era_t                          era = ERA_SLOW_SINK;
	era_t                          sink_era = ERA_SLOW_SINK;
	int                            hold_left = 0;
	logic [THR_BITS-1:0]           cur_peak_thr = THR_RESET;
	logic [THR_BITS-1:0]           cur_sag_thr = THR_RESET;

	// Opening sequence, run with the thresholds at their reset value. The
	// first request finds both prior samples at zero. Then come the full-scale
	// valley and peak, a peak exactly at the threshold and one just under it,
	// a valley exactly at minus the threshold and one just above it (a sag),
	// a zero peak, several flat neighbors, and the alternating bit patterns.
	int directed_samples[19] = '{
		-32768, 32767, -32768, 0, 2867, 0, 2866, 0, -2867, 0,
		-2866, 0, 0, 100, 100, 50, -1, 21845, -21846
	};

	peak_valley_sag_tracker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.extreme_value  (extreme_value),
		.running_average(running_average),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	pvst_checker #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.event_kind     (event_kind),
		.extreme_value  (extreme_value),
		.running_average(running_average),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver decides its stall at every falling edge. When the bench
	// enters the full-rate era it first holds off for a long stretch, so the
	// output register fills, the block runs out of room and stalls the
	// sender, who keeps offering requests all the while.
	always @(negedge clk) begin
		if (era == ERA_FULL_RATE && sink_era != ERA_FULL_RATE)
			hold_left = LONG_HOLD_CYCLES;
		sink_era = era;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (era)
				ERA_SLOW_SINK:   out_stall <= ($urandom_range(99) < 62);
				ERA_SLOW_SOURCE: out_stall <= ($urandom_range(99) < 23);
				default:         out_stall <= 1'b0;
			endcase
		end
	end

	// Offers one sample, starting and ending at a falling edge. Valid is only
	// lowered while the sender idles, so back-to-back requests keep it high.
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
		int idle_pct;
		case (era)
			ERA_SLOW_SINK:   idle_pct = 23;
			ERA_SLOW_SOURCE: idle_pct = 62;
			default:         idle_pct = 0;
		endcase
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Waits until every predicted event has come out, then lets the block
	// finish any request that produces nothing.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
			input logic [THR_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	// Writes both thresholds while the block is idle. With with_spares set,
	// the unused indexes get a zero afterwards, which must be ignored.
	task automatic program_thresholds(input logic [THR_BITS-1:0] peak_value,
			input logic [THR_BITS-1:0] sag_value, input bit with_spares);
		wait_idle();
		write_register(CFG_PEAK_THR, peak_value);
		write_register(CFG_SAG_THR, sag_value);
		if (with_spares) begin
			write_register(CFG_SPARE_LO, '0);
			write_register(CFG_SPARE_HI, '0);
		end
		cfg_valid <= 1'b0;
		cur_peak_thr = peak_value;
		cur_sag_thr = sag_value;
	endtask

	// Random samples lean toward what makes events: swings of opposite sign,
	// values around both thresholds, repeats that make flat neighbors, and
	// the full-scale extremes.
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int v;
		case ($urandom_range(9))
			0, 1: v = int'($urandom);
			2:    v = int'(sample);
			3:    v = int'(cur_peak_thr) + int'($urandom_range(4)) - 2;
			4:    v = -int'(cur_sag_thr) + int'($urandom_range(4)) - 2;
			5:    v = $urandom_range(1) ? 32767 : -32768;
			default: begin
				if (sample >= 0)
					v = -int'($urandom_range(6000));
				else
					v = int'($urandom_range(6000));
			end
		endcase
		return SAMPLE_BITS'(v);
	endfunction

	initial begin
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_samples[i])
			send_sample(SAMPLE_BITS'(directed_samples[i]));

		// Two blocks per idling era, each under its own threshold setting.
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			case (blk)
				0: ;
				1: program_thresholds('0, '0, 1'b0);
				2: program_thresholds('1, '1, 1'b1);
				3: program_thresholds(THR_BITS'($urandom_range(8191)),
					THR_BITS'($urandom_range(8191)), 1'b0);
				4: program_thresholds('0, '1, 1'b0);
				default: program_thresholds(THR_BITS'($urandom),
					THR_BITS'($urandom), 1'b1);
			endcase
			era = era_t'(blk / 2);
			repeat (ITEMS_PER_BLOCK)
				send_sample(pick_sample());
		end

		// A closing full-scale crest, so the last request reports a peak unless the sample before it was also full scale.
		send_sample(SAMPLE_BITS'(32767));
		send_sample('0);

		wait_idle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
